### src/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the sorted priority queue.
// Depends on nothing; used by spq_cell and sorted_priority_queue.

package spq_pkg;

    localparam int CAP_W  = 5;
    localparam int BYTE_W = 8;
    localparam int OCC_W  = 5;

    localparam logic [BYTE_W-1:0] CHAR_X = 8'd120;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_CREATED = 2'd1,
        ST_FULL        = 2'd2,
        ST_EMPTY       = 2'd3
    } status_t;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### src/spq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One storage cell of the sorted chain: holds a byte and its priority.
// Depends on spq_pkg (cell_ctrl_t, BYTE_W).

module spq_cell #(
    parameter int PRIO_WIDTH = 16
) (
    input  wire                              clk,
    input  wire spq_pkg::cell_ctrl_t         ctrl,
    input  wire                              valid,
    input  wire [spq_pkg::BYTE_W-1:0]        new_byte,
    input  wire signed [PRIO_WIDTH-1:0]      new_prio,
    input  wire                              left_ins,
    input  wire [spq_pkg::BYTE_W-1:0]        left_byte,
    input  wire signed [PRIO_WIDTH-1:0]      left_prio,
    input  wire [spq_pkg::BYTE_W-1:0]        right_byte,
    input  wire signed [PRIO_WIDTH-1:0]      right_prio,
    output logic                             ins,
    output logic [spq_pkg::BYTE_W-1:0]       byte_q,
    output logic signed [PRIO_WIDTH-1:0]     prio_q
);

    logic [spq_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic signed [PRIO_WIDTH-1:0] prio_reg, prio_next;

    // an empty cell ranks below any key, so the insert point is the first
    // cell with strictly lower priority or the first empty one
    assign ins = valid ? (new_prio > prio_reg) : 1'b1;

    always_comb
    begin
        byte_next = byte_reg;
        prio_next = prio_reg;
        if (ctrl.deq)
        begin
            // advance towards the front
            byte_next = right_byte;
            prio_next = right_prio;
        end
        else if (ctrl.enq && ins)
        begin
            if (left_ins)
            begin
                byte_next = left_byte;
                prio_next = left_prio;
            end
            else
            begin
                byte_next = new_byte;
                prio_next = new_prio;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        prio_reg <= prio_next;
    end

    assign byte_q = byte_reg;
    assign prio_q = prio_reg;

endmodule

`default_nettype wire

### src/sorted_priority_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the sorted priority queue: count, capacity and result logic
// around a chain of spq_cell instances. Depends on spq_pkg and spq_cell.
//
//  channel   handshake          payload
//  command   start / busy       action, element, priority_req
//  result    done (strobe)      data_out, status, occupancy
//  config    cfg_we             cfg_data (capacity)
//
// One command per cycle: every cell compares its priority against the key and
// shifts in the same clock, so busy stays low. The result beat appears on the
// cycle after the command is taken and lasts one cycle; it cannot be stalled.
// Reset empties the queue and sets capacity to 16; a capacity write empties
// it as well. Cell contents are not reset.

module sorted_priority_queue #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 16
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                action,
    input  wire [spq_pkg::BYTE_W-1:0]          element,
    input  wire signed [PRIO_WIDTH-1:0]        priority_req,
    output logic                               done,
    output logic [spq_pkg::BYTE_W-1:0]         data_out,
    output logic [1:0]                         status,
    output logic [spq_pkg::OCC_W-1:0]          occupancy,
    input  wire                                cfg_we,
    input  wire [spq_pkg::CAP_W-1:0]           cfg_data
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > spq_pkg::CAP_W) ? CW : spq_pkg::CAP_W;

    logic [CW-1:0]                  count_reg, count_next;
    logic [spq_pkg::CAP_W-1:0]      capacity_reg;
    logic                           done_reg;
    logic [spq_pkg::BYTE_W-1:0]     data_out_reg, data_out_next;
    spq_pkg::status_t               status_reg, status_next;
    logic [spq_pkg::OCC_W-1:0]      occupancy_reg;

    logic [CMPW-1:0]                cap_ext, depth_ext, lim, count_ext, count_next_ext;
    logic                           accept;
    logic                           do_enq, do_deq;
    spq_pkg::cell_ctrl_t            ctrl;

    logic [spq_pkg::BYTE_W-1:0]     cell_byte [DEPTH];
    logic signed [PRIO_WIDTH-1:0]   cell_prio [DEPTH];
    logic [DEPTH-1:0]               cell_ins;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign cap_ext   = CMPW'(capacity_reg);
    assign depth_ext = CMPW'(DEPTH);
    assign lim       = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign count_ext = CMPW'(count_reg);

    always_comb
    begin
        do_enq        = 1'b0;
        do_deq        = 1'b0;
        count_next    = count_reg;
        data_out_next = '0;
        status_next   = spq_pkg::ST_OK;
        if (lim == '0)
        begin
            status_next   = spq_pkg::ST_NOT_CREATED;
            data_out_next = action ? spq_pkg::CHAR_X : '0;
        end
        else if (action)
        begin
            if (count_reg == '0)
            begin
                status_next   = spq_pkg::ST_EMPTY;
                data_out_next = spq_pkg::CHAR_X;
            end
            else
            begin
                do_deq        = 1'b1;
                data_out_next = cell_byte[0];
                count_next    = count_reg - CW'(1);
            end
        end
        else
        begin
            if (count_ext >= lim)
            begin
                status_next = spq_pkg::ST_FULL;
            end
            else
            begin
                do_enq     = 1'b1;
                count_next = count_reg + CW'(1);
            end
        end
    end

    assign count_next_ext = CMPW'(count_next);

    assign ctrl.enq = accept && do_enq;
    assign ctrl.deq = accept && do_deq;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                          l_ins;
            logic [spq_pkg::BYTE_W-1:0]    l_byte, r_byte;
            logic signed [PRIO_WIDTH-1:0]  l_prio, r_prio;
            logic                          valid;

            assign valid = (count_ext > CMPW'(gi));

            if (gi == 0)
            begin : g_head
                assign l_ins  = 1'b0;
                assign l_byte = element;
                assign l_prio = priority_req;
            end
            else
            begin : g_body
                assign l_ins  = cell_ins[gi-1];
                assign l_byte = cell_byte[gi-1];
                assign l_prio = cell_prio[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_byte = cell_byte[gi];
                assign r_prio = cell_prio[gi];
            end
            else
            begin : g_mid
                assign r_byte = cell_byte[gi+1];
                assign r_prio = cell_prio[gi+1];
            end

            spq_cell #(
                .PRIO_WIDTH (PRIO_WIDTH)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (valid),
                .new_byte   (element),
                .new_prio   (priority_req),
                .left_ins   (l_ins),
                .left_byte  (l_byte),
                .left_prio  (l_prio),
                .right_byte (r_byte),
                .right_prio (r_prio),
                .ins        (cell_ins[gi]),
                .byte_q     (cell_byte[gi]),
                .prio_q     (cell_prio[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= spq_pkg::CAP_W'(16);
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (cfg_we)
            begin
                // re-create the queue
                capacity_reg <= cfg_data;
                count_reg    <= '0;
            end
            else if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg  <= data_out_next;
            status_reg    <= status_next;
            occupancy_reg <= count_next_ext[spq_pkg::OCC_W-1:0];
        end
    end

    assign done      = done_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= lim)
        else $error("entry count above capacity limit");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("result beat without a command");

    a_deq_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.deq && !cfg_we) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("dequeue did not drop one entry");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we) |=> (occupancy == count_ext[spq_pkg::OCC_W-1:0]))
        else $error("reported occupancy differs from entry count");

endmodule

`default_nettype wire
